// File: design/ascii_glyph_color_cell_diff_assert.svh
// Assertion macros for the ascii_glyph_color_cell_diff modules; agccd_back uses them.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef ASCII_GLYPH_COLOR_CELL_DIFF_ASSERT_SVH
`define ASCII_GLYPH_COLOR_CELL_DIFF_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AGCCD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AGCCD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/agccd_pkg.sv
// Package for the ascii_glyph_color_cell_diff block: sizes, word types,
// the glyph ramp, the luma weights and the glyph and color functions. No dependencies.
`timescale 1ns / 1ps

package agccd_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 128;
    localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CELL_W      = 15;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int PADDR_W = 3;
    localparam logic REG_COLOR_ENABLE = 1'b0;
    localparam logic REG_INVERT_COLOR = 1'b1;

    localparam logic [15:0] LUMA_WR = 16'd19595;
    localparam logic [15:0] LUMA_WG = 16'd38470;
    localparam logic [15:0] LUMA_WB = 16'd7471;

    localparam int RAMP_LEN  = 70;
    localparam int RAMP_LAST = RAMP_LEN - 1;
    localparam logic [8*RAMP_LEN-1:0] GLYPH_RAMP = {
        " .'", 8'h60, "^\",:;Il!i><~+_-?][}{1)(|\\/tfjrxnuvcz",
        "XYUJCLQ0OZmwqpdbkhao*#MW&8%B$@"
    };

    typedef struct packed {
        logic color_enable;
        logic invert_color;
    } cfg_t;

    typedef struct packed {
        logic [6:0]        row;
        logic [7:0]        column;
        logic [6:0]        glyph;
        logic [7:0]        ansi_color;
        logic              frame_end;
        logic              first;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
    } work_t;

    typedef struct packed {
        logic [6:0] cell_row;
        logic [7:0] cell_column;
        logic [6:0] glyph;
        logic [7:0] ansi_color;
        logic       changed;
        logic       move_cursor;
        logic       last_cell;
    } result_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    function automatic logic [2:0] cube_level(input logic [7:0] c);
        logic [2:0] lvl;
        lvl = 3'd0;
        if (c >= 8'd51)  lvl = 3'd1;
        if (c >= 8'd102) lvl = 3'd2;
        if (c >= 8'd153) lvl = 3'd3;
        if (c >= 8'd204) lvl = 3'd4;
        if (c == 8'd255) lvl = 3'd5;
        return lvl;
    endfunction

    function automatic logic [7:0] cube_code(input logic [2:0] r, input logic [2:0] g,
                                             input logic [2:0] b);
        return 8'd16 + 8'(r) * 8'd36 + 8'(g) * 8'd6 + 8'(b);
    endfunction

    // Index luma * 69 / 255: the quotient by 256 is low by at most one.
    function automatic logic [6:0] glyph_index(input logic [7:0] luma);
        logic [14:0] x;
        logic [6:0]  q;
        logic [8:0]  rem;
        x   = 15'(luma) * 15'd69;
        q   = x[14:8];
        rem = 9'(x[7:0]) + 9'(q);
        if (rem >= 9'd255) q = q + 7'd1;
        return q;
    endfunction

    function automatic logic [6:0] glyph_of(input logic [6:0] idx);
        logic [6:0] i;
        i = (idx > 7'(RAMP_LAST)) ? 7'(RAMP_LAST) : idx;
        return GLYPH_RAMP[8 * (RAMP_LAST - int'(i)) +: 7];
    endfunction

endpackage

// File: design/agccd_queue.sv
// Short word queue between the front and back parts of the cell differ.
// Depends on agccd_pkg.
`timescale 1ns / 1ps

module agccd_queue
    import agccd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  work_t   wr_data,
    input  logic    pop,
    output work_t   rd_data,
    output q_stat_t stat
);

    work_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

endmodule

// File: design/agccd_front.sv
// Front part: accepts pixels, tags the first frame, computes luma, glyph,
// color code and store address over two stages. Depends on agccd_pkg.
`timescale 1ns / 1ps

module agccd_front
    import agccd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [6:0] row,
    input  logic [7:0] column,
    input  logic       frame_end,
    input  cfg_t       cfg,
    input  q_stat_t    q_stat,
    output logic       q_push,
    output work_t      q_data
);

    logic              accept;
    logic [QCNT_W:0]   credit;
    logic              redraw_all_reg;
    logic              redraw_all_next;

    logic              s1_valid_reg;
    logic [7:0]        s1_red_reg;
    logic [7:0]        s1_green_reg;
    logic [7:0]        s1_blue_reg;
    logic [6:0]        s1_row_reg;
    logic [7:0]        s1_column_reg;
    logic              s1_frame_end_reg;
    logic              s1_first_reg;

    logic [23:0]       luma_sum;
    logic [7:0]        cr;
    logic [7:0]        cg;
    logic [7:0]        cb;
    logic [7:0]        code_c;
    logic              in_range_c;
    logic [ADDR_W-1:0] addr_c;

    logic              s2_valid_reg;
    logic [7:0]        s2_luma_reg;
    work_t             s2_work_reg;

    assign credit = (QCNT_W + 1)'(q_stat.count) + (QCNT_W + 1)'(s1_valid_reg)
                  + (QCNT_W + 1)'(s2_valid_reg);
    assign full   = (credit >= (QCNT_W + 1)'(QDEPTH));
    assign accept = push && !full;

    assign redraw_all_next = (accept && frame_end) ? 1'b0 : redraw_all_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            redraw_all_reg <= 1'b1;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            redraw_all_reg <= redraw_all_next;
            s1_valid_reg   <= accept;
            s2_valid_reg   <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_red_reg       <= red;
            s1_green_reg     <= green;
            s1_blue_reg      <= blue;
            s1_row_reg       <= row;
            s1_column_reg    <= column;
            s1_frame_end_reg <= frame_end;
            s1_first_reg     <= redraw_all_reg;
        end
    end

    always_comb
    begin
        luma_sum = 24'(LUMA_WR) * 24'(s1_red_reg) + 24'(LUMA_WG) * 24'(s1_green_reg)
                 + 24'(LUMA_WB) * 24'(s1_blue_reg);
        cr = cfg.invert_color ? ~s1_red_reg : s1_red_reg;
        cg = cfg.invert_color ? ~s1_green_reg : s1_green_reg;
        cb = cfg.invert_color ? ~s1_blue_reg : s1_blue_reg;
        code_c = cfg.color_enable
               ? cube_code(cube_level(cr), cube_level(cg), cube_level(cb)) : 8'd0;
        in_range_c = (32'(s1_row_reg) < MAX_ROWS) && (32'(s1_column_reg) < MAX_COLUMNS);
        addr_c = ADDR_W'(32'(s1_row_reg) * MAX_COLUMNS + 32'(s1_column_reg));
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_luma_reg            <= luma_sum[23:16];
            s2_work_reg.row        <= s1_row_reg;
            s2_work_reg.column     <= s1_column_reg;
            s2_work_reg.glyph      <= '0;
            s2_work_reg.ansi_color <= code_c;
            s2_work_reg.frame_end  <= s1_frame_end_reg;
            s2_work_reg.first      <= s1_first_reg;
            s2_work_reg.in_range   <= in_range_c;
            s2_work_reg.addr       <= addr_c;
        end
    end

    always_comb
    begin
        q_data       = s2_work_reg;
        q_data.glyph = glyph_of(glyph_index(s2_luma_reg));
    end

    assign q_push = s2_valid_reg;

endmodule

// File: design/agccd_back.sv
// Back part: read-modify-write of the cell store, change detection and a
// two-word result queue. Depends on agccd_pkg and the assertion header.
`timescale 1ns / 1ps
`include "ascii_glyph_color_cell_diff_assert.svh"

module agccd_back
    import agccd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  work_t      q_data,
    input  q_stat_t    q_stat,
    output logic       q_pop,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] cell_row,
    output logic [7:0] cell_column,
    output logic [6:0] glyph,
    output logic [7:0] ansi_color,
    output logic       changed,
    output logic       move_cursor,
    output logic       last_cell
);

    logic [CELL_W-1:0] store_mem [STORE_DEPTH];
    logic [CELL_W-1:0] rd_data_reg;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    work_t             s1_reg;
    logic              fwd_hit_reg;
    logic [CELL_W-1:0] fwd_data_reg;

    logic              s1_adv;
    logic              load;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [CELL_W-1:0] stored;
    logic              changed_c;
    logic              move_c;

    result_t           out_reg [2];
    logic              out_wr_ptr_reg;
    logic              out_rd_ptr_reg;
    logic [1:0]        out_cnt_reg;
    logic [1:0]        out_cnt_next;
    logic              out_pop;

    assign s1_adv = s1_valid_reg && (out_cnt_reg != 2'd2);
    assign load   = !q_stat.empty && (!s1_valid_reg || s1_adv);
    assign q_pop  = load;

    assign wr_en   = s1_adv && s1_reg.in_range;
    assign wr_addr = s1_reg.addr;
    assign wr_data = {s1_reg.ansi_color, s1_reg.glyph};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (load)
        begin
            rd_data_reg <= store_mem[q_data.addr];
        end
    end

    // A word loaded at the same edge as the write of its predecessor sees
    // the old memory contents, so the written value is kept alongside it.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_reg       <= q_data;
            fwd_hit_reg  <= wr_en && (wr_addr == q_data.addr);
            fwd_data_reg <= wr_data;
        end
    end

    assign s1_valid_next = load || (s1_valid_reg && !s1_adv);

    always_comb
    begin
        stored    = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        changed_c = !s1_reg.in_range || s1_reg.first || (stored != wr_data);
        move_c    = changed_c && !s1_reg.first;
    end

    assign out_pop = pop && (out_cnt_reg != 2'd0);

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (s1_adv && !out_pop)
        begin
            out_cnt_next = out_cnt_reg + 2'd1;
        end
        else if (out_pop && !s1_adv)
        begin
            out_cnt_next = out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_wr_ptr_reg <= 1'b0;
            out_rd_ptr_reg <= 1'b0;
            out_cnt_reg    <= 2'd0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_cnt_reg  <= out_cnt_next;
            if (s1_adv)
            begin
                out_wr_ptr_reg <= ~out_wr_ptr_reg;
            end
            if (out_pop)
            begin
                out_rd_ptr_reg <= ~out_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_reg[out_wr_ptr_reg] <= '{
                cell_row:    s1_reg.row,
                cell_column: s1_reg.column,
                glyph:       s1_reg.glyph,
                ansi_color:  s1_reg.ansi_color,
                changed:     changed_c,
                move_cursor: move_c,
                last_cell:   s1_reg.frame_end
            };
        end
    end

    assign empty       = (out_cnt_reg == 2'd0);
    assign cell_row    = out_reg[out_rd_ptr_reg].cell_row;
    assign cell_column = out_reg[out_rd_ptr_reg].cell_column;
    assign glyph       = out_reg[out_rd_ptr_reg].glyph;
    assign ansi_color  = out_reg[out_rd_ptr_reg].ansi_color;
    assign changed     = out_reg[out_rd_ptr_reg].changed;
    assign move_cursor = out_reg[out_rd_ptr_reg].move_cursor;
    assign last_cell   = out_reg[out_rd_ptr_reg].last_cell;

    `AGCCD_ASSERT_IMP(a_first_frame_redraw, s1_valid_reg && s1_reg.first,
        changed_c && !move_c, "First-frame cell not marked for full redraw.")
    `AGCCD_ASSERT_IMP(a_outside_changed, s1_valid_reg && !s1_reg.in_range,
        changed_c && !wr_en, "Cell outside the store not handled as changed.")
    `AGCCD_ASSERT_NXT(a_stall_holds, s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(s1_reg), "Stalled store word changed or vanished.")
    `AGCCD_ASSERT_IMP(a_out_bound, s1_adv, out_cnt_reg != 2'd2,
        "Result queue written while full.")

endmodule

// File: design/ascii_glyph_color_cell_diff.sv
// An accepted word passes the front stages, the word queue, the back stage and the
// result queue. Throughput: one word per cycle while full is low, set by the single
// read-modify-write port of the 32768-entry cell store, with the last write
// forwarded to the next word. Reset clears the configuration and queues, sets the
// first-frame flag and leaves the cell store uncleared; words are taken right away.
`timescale 1ns / 1ps

module ascii_glyph_color_cell_diff
    import agccd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [6:0]         row,
    input  logic [7:0]         column,
    input  logic               frame_end,
    output logic               empty,
    input  logic               pop,
    output logic [6:0]         cell_row,
    output logic [7:0]         cell_column,
    output logic [6:0]         glyph,
    output logic [7:0]         ansi_color,
    output logic               changed,
    output logic               move_cursor,
    output logic               last_cell
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    cfg_write;
    logic    q_push;
    logic    q_pop;
    work_t   q_wr_data;
    work_t   q_rd_data;
    q_stat_t q_stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_COLOR_ENABLE: cfg_next.color_enable = pwdata[0];
                REG_INVERT_COLOR: cfg_next.invert_color = pwdata[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign prdata = (paddr[2] == REG_INVERT_COLOR) ? 32'(cfg_reg.invert_color)
                                                   : 32'(cfg_reg.color_enable);

    agccd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .row       (row),
        .column    (column),
        .frame_end (frame_end),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_data    (q_wr_data)
    );

    agccd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    agccd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_data      (q_rd_data),
        .q_stat      (q_stat),
        .q_pop       (q_pop),
        .empty       (empty),
        .pop         (pop),
        .cell_row    (cell_row),
        .cell_column (cell_column),
        .glyph       (glyph),
        .ansi_color  (ansi_color),
        .changed     (changed),
        .move_cursor (move_cursor),
        .last_cell   (last_cell)
    );

endmodule

// File: tb/sv/tb_ascii_glyph_color_cell_diff.sv
// Testbench for ascii_glyph_color_cell_diff: streams frames of pixels through the queue ports,
// predicts glyph, color code and redraw flags per cell, and checks every word that pops out.
// Depends on agccd_pkg and the ascii_glyph_color_cell_diff RTL.
`timescale 1ns / 1ps

module tb_ascii_glyph_color_cell_diff;
    import agccd_pkg::*;

    localparam int LONG_HOLD   = 90;
    localparam int PHASE_CELLS = 148;
    localparam int FILL_CELLS  = 48;

    localparam logic [PADDR_W-1:0] ADDR_COLOR_ENABLE = PADDR_W'({REG_COLOR_ENABLE, 2'b00});
    localparam logic [PADDR_W-1:0] ADDR_INVERT_COLOR = PADDR_W'({REG_INVERT_COLOR, 2'b00});

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] row;
        logic [7:0] column;
        logic       frame_end;
    } pixel_cell_t;

    typedef enum int {POP_ALWAYS, POP_MOSTLY, POP_PERIODIC, POP_SPARSE} pop_mode_t;

    class cell_scoreboard;
        logic        color_on;
        logic        invert_on;
        logic        full_redraw;
        logic [14:0] cell_memory [STORE_DEPTH];
        result_t     awaited [$];
        string       ramp;
        int unsigned matched;
        int unsigned mismatches;

        function new();
            ramp = " .'X^\",:;Il!i><~+_-?][}{1)(|\\/tfjrxnuvczXYUJCLQ0OZmwqpdbkhao*#MW&8%B$@";
            ramp.putc(3, 8'h60);
            color_on    = 1'b0;
            invert_on   = 1'b0;
            full_redraw = 1'b1;
            matched     = 0;
            mismatches  = 0;
            foreach (cell_memory[i]) cell_memory[i] = '0;
        endfunction

        function void apply_register(logic index, logic value);
            if (index == REG_COLOR_ENABLE) color_on = value;
            else invert_on = value;
        endfunction

        function logic [2:0] channel_level(logic [7:0] c);
            int unsigned v;
            v = invert_on ? 255 - int'(c) : int'(c);
            v = v / 51;
            if (v > 5) v = 5;
            return v[2:0];
        endfunction

        function void note_cell(pixel_cell_t c);
            int unsigned luma;
            int unsigned idx;
            int unsigned addr;
            logic [7:0]  ch;
            logic [14:0] packed_cell;
            result_t     want;
            luma = (32'd19595 * c.red + 32'd38470 * c.green + 32'd7471 * c.blue) >> 16;
            idx  = luma * 69 / 255;
            if (idx > 69) idx = 69;
            ch = ramp.getc(idx);
            want.cell_row    = c.row;
            want.cell_column = c.column;
            want.glyph       = ch[6:0];
            if (color_on)
                want.ansi_color = 8'(16 + 36 * channel_level(c.red)
                                  + 6 * channel_level(c.green) + channel_level(c.blue));
            else
                want.ansi_color = 8'd0;
            packed_cell = {want.ansi_color, want.glyph};
            addr = int'(c.row) * MAX_COLUMNS + int'(c.column);
            want.changed     = full_redraw || (cell_memory[addr] != packed_cell);
            cell_memory[addr] = packed_cell;
            want.move_cursor = want.changed && !full_redraw;
            want.last_cell   = c.frame_end;
            if (c.frame_end) full_redraw = 1'b0;
            awaited.push_back(want);
        endfunction

        function void check_result(result_t seen);
            result_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected word: row=%0d col=%0d glyph=%0d code=%0d",
                             seen.cell_row, seen.cell_column, seen.glyph, seen.ansi_color);
                return;
            end
            want = awaited.pop_front();
            if (seen !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Mismatch: expected row=%0d col=%0d glyph=%0d code=%0d changed=%0b move=%0b last=%0b",
                             want.cell_row, want.cell_column, want.glyph, want.ansi_color,
                             want.changed, want.move_cursor, want.last_cell);
                    $display("          got      row=%0d col=%0d glyph=%0d code=%0d changed=%0b move=%0b last=%0b",
                             seen.cell_row, seen.cell_column, seen.glyph, seen.ansi_color,
                             seen.changed, seen.move_cursor, seen.last_cell);
                end
            end
            else
            begin
                matched++;
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    bit                 clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               push;
    logic               full;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [6:0]         row;
    logic [7:0]         column;
    logic               frame_end;
    logic               empty;
    logic               pop;
    logic [6:0]         cell_row;
    logic [7:0]         cell_column;
    logic [6:0]         glyph;
    logic [7:0]         ansi_color;
    logic               changed;
    logic               move_cursor;
    logic               last_cell;

    cell_scoreboard sb = new();

    bit          hold_req;
    int unsigned long_holds;
    int unsigned reg_errors;
    int unsigned burst_left;
    int unsigned frames_sent;
    int unsigned cells_sent;
    logic [14:0] visited [$];
    logic [23:0] last_pixel [int];

    ascii_glyph_color_cell_diff u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .push        (push),
        .full        (full),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .row         (row),
        .column      (column),
        .frame_end   (frame_end),
        .empty       (empty),
        .pop         (pop),
        .cell_row    (cell_row),
        .cell_column (cell_column),
        .glyph       (glyph),
        .ansi_color  (ansi_color),
        .changed     (changed),
        .move_cursor (move_cursor),
        .last_cell   (last_cell)
    );

    always #6 clk = ~clk;

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && pop && !empty)
            sb.check_result({cell_row, cell_column, glyph, ansi_color,
                             changed, move_cursor, last_cell});
    end

    initial
    begin
        pop_mode_t   mode;
        int unsigned mode_left;
        int unsigned cyc;
        pop <= 1'b0;
        mode = POP_ALWAYS;
        mode_left = 0;
        cyc = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && long_holds == 0)
            begin
                pop <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_holds++;
            end
            if (mode_left == 0)
            begin
                mode = pop_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            cyc++;
            case (mode)
                POP_ALWAYS:   pop <= 1'b1;
                POP_MOSTLY:   pop <= ($urandom_range(0, 9) < 7);
                POP_PERIODIC: pop <= (cyc % 4 != 0);
                default:      pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    task automatic reg_write(logic index, logic value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (index == REG_COLOR_ENABLE) ? ADDR_COLOR_ENABLE : ADDR_INVERT_COLOR;
        pwdata  <= {31'($urandom()), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.apply_register(index, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_check(logic index, logic value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= (index == REG_COLOR_ENABLE) ? ADDR_COLOR_ENABLE : ADDR_INVERT_COLOR;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== {31'd0, value})
        begin
            reg_errors++;
            $display("Register %0d read back %0h, expected %0h", index, prdata, value);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_colors(logic color_value, logic invert_value);
        reg_write(REG_COLOR_ENABLE, color_value);
        reg_write(REG_INVERT_COLOR, invert_value);
        reg_check(REG_COLOR_ENABLE, color_value);
        reg_check(REG_INVERT_COLOR, invert_value);
    endtask

    // Words go out in bursts; a new burst may start after an idle gap of random length.
    task automatic drive_cell(pixel_cell_t c);
        int unsigned gap;
        int          key;
        key = {c.row, c.column};
        if (!last_pixel.exists(key)) visited.push_back({c.row, c.column});
        last_pixel[key] = {c.red, c.green, c.blue};
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        push      <= 1'b1;
        red       <= c.red;
        green     <= c.green;
        blue      <= c.blue;
        row       <= c.row;
        column    <= c.column;
        frame_end <= c.frame_end;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_cell(c);
        cells_sent++;
        if (c.frame_end) frames_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic pixel_cell_t make_cell(int rw, int col, int r, int g, int b, bit fe);
        pixel_cell_t c;
        c.row       = 7'(rw);
        c.column    = 8'(col);
        c.red       = 8'(r);
        c.green     = 8'(g);
        c.blue      = 8'(b);
        c.frame_end = fe;
        return c;
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 2))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Revisits only cells written in the first frame, so no stale entry is ever read.
    task automatic random_frames(int unsigned count);
        pixel_cell_t c;
        logic [14:0] pos;
        logic [23:0] pix;
        int unsigned sel;
        repeat (count)
        begin
            pos = visited[$urandom_range(0, visited.size() - 1)];
            pix = last_pixel[pos];
            sel = $urandom_range(0, 99);
            if (sel < 35)
                c = make_cell(pos[14:8], pos[7:0], pix[23:16], pix[15:8], pix[7:0], 1'b0);
            else if (sel < 50)
                c = make_cell(pos[14:8], pos[7:0], pix[23:16], pix[15:8], pix[7:0] ^ 8'd1, 1'b0);
            else if (sel < 62)
                c = make_cell(pos[14:8], pos[7:0], pick_channel(), pick_channel(),
                              pick_channel(), 1'b0);
            else
                c = make_cell(pos[14:8], pos[7:0], $urandom_range(0, 255),
                              $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
            c.frame_end = ($urandom_range(0, 29) == 0);
            drive_cell(c);
        end
    endtask

    initial
    begin
        logic [1:0] settings [6];
        pixel_cell_t c;
        settings = '{2'b11, 2'b00, 2'b01, 2'b10, 2'b11, 2'b00};
        rst_n     <= 1'b0;
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        paddr     <= '0;
        pwdata    <= '0;
        push      <= 1'b0;
        red       <= '0;
        green     <= '0;
        blue      <= '0;
        row       <= '0;
        column    <= '0;
        frame_end <= 1'b0;
        hold_req    = 1'b0;
        long_holds  = 0;
        reg_errors  = 0;
        burst_left  = 0;
        frames_sent = 0;
        cells_sent  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        reg_check(REG_COLOR_ENABLE, 1'b0);
        reg_check(REG_INVERT_COLOR, 1'b0);
        set_colors(1'b1, 1'b0);

        // First frame: every cell redraws, even a repeated one.
        drive_cell(make_cell(0, 0, 0, 0, 0, 1'b0));
        drive_cell(make_cell(127, 255, 255, 255, 255, 1'b0));
        drive_cell(make_cell(0, 255, 255, 0, 0, 1'b0));
        drive_cell(make_cell(127, 0, 0, 255, 0, 1'b0));
        drive_cell(make_cell(64, 128, 0, 0, 255, 1'b0));
        drive_cell(make_cell(1, 2, 50, 51, 101, 1'b0));
        drive_cell(make_cell(2, 1, 102, 152, 153, 1'b0));
        drive_cell(make_cell(85, 170, 203, 204, 254, 1'b0));
        drive_cell(make_cell(42, 85, 254, 1, 128, 1'b0));
        drive_cell(make_cell(0, 0, 0, 0, 0, 1'b0));
        for (int i = 0; i < FILL_CELLS; i++)
        begin
            c = make_cell($urandom_range(0, 127), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), i == FILL_CELLS - 1);
            drive_cell(c);
        end

        // Second frame: two unchanged cells, a changed one, and a glyph-only change.
        drive_cell(make_cell(0, 0, 0, 0, 0, 1'b0));
        drive_cell(make_cell(127, 255, 0, 0, 0, 1'b0));
        drive_cell(make_cell(0, 255, 255, 0, 0, 1'b0));
        drive_cell(make_cell(127, 0, 0, 255, 50, 1'b0));

        for (int p = 0; p < 6; p++)
        begin
            drain();
            set_colors(settings[p][1], settings[p][0]);
            if (p == 0) hold_req = 1'b1;
            random_frames(PHASE_CELLS);
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d cells in %0d completed frames across 7 color settings.",
                 cells_sent, frames_sent);
        $display("Matched %0d words; receiver held off %0d time(s) for %0d cycles.",
                 sb.matched, long_holds, LONG_HOLD);
        if (sb.mismatches == 0 && reg_errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
